FILE: rtl/core/anem_pkg.sv
// Shared types and constants for the anemometer speed and limit alarm block.
// Used by anem_divider, anem_limit_check and anemometer_speed_threshold_alarm.
// No dependencies.
package anem_pkg;

  // Field widths
  localparam int COUNT_W = 12;
  localparam int SPEED_W = 13;
  localparam int TEMP_W  = 11;
  localparam int HUM_W   = 10;
  localparam int PRES_W  = 14;

  // Register widths
  localparam int TEMP_LIM_W = 8;
  localparam int HUM_LIM_W  = 7;
  localparam int PRES_LIM_W = 11;
  localparam int WIND_LIM_W = 6;

  // Configuration port widths
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 11;

  // Speed in tenths of km/h is SPEED_NUMERATOR / period (5.6 * pi * 36 * 10, rounded).
  localparam logic [SPEED_W-1:0] SPEED_NUMERATOR = 13'd6333;
  localparam logic [COUNT_W-1:0] TIMEOUT_TICKS   = 12'd2000;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 12'd4095;

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS = SPEED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMPERATURE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUMIDITY    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIND        = 8'd3;

  // Reset values of the limits
  localparam logic [TEMP_LIM_W-1:0] TEMP_LIM_RESET = 8'd40;
  localparam logic [HUM_LIM_W-1:0]  HUM_LIM_RESET  = 7'd80;
  localparam logic [PRES_LIM_W-1:0] PRES_LIM_RESET = 11'd1050;
  localparam logic [WIND_LIM_W-1:0] WIND_LIM_RESET = 6'd10;

  typedef enum logic [2:0] {
    TONE_NONE        = 3'd0,
    TONE_TEMPERATURE = 3'd1,
    TONE_PRESSURE    = 3'd2,
    TONE_HUMIDITY    = 3'd3,
    TONE_WIND        = 3'd4
  } tone_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic signed [TEMP_LIM_W-1:0] temperature;
    logic [HUM_LIM_W-1:0]         humidity;
    logic [PRES_LIM_W-1:0]        pressure;
    logic [WIND_LIM_W-1:0]        wind;
  } limits_t;

  typedef struct packed {
    logic  latch_next;
    tone_t tone;
  } check_t;

endpackage

FILE: rtl/core/anem_divider.sv
// Iterative restoring divider: 13-bit numerator by 12-bit divisor.
// One quotient bit per cycle; depends on anem_pkg.
module anem_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [anem_pkg::SPEED_W-1:0]    numerator,
  input  logic [anem_pkg::COUNT_W-1:0]    divisor,
  output logic                            busy,
  output logic                            done,
  output logic [anem_pkg::SPEED_W-1:0]    quotient
);

  logic [anem_pkg::COUNT_W-1:0]   rem;
  logic [anem_pkg::COUNT_W-1:0]   dvs;
  logic [anem_pkg::DIV_CNT_W-1:0] cnt;
  logic [anem_pkg::COUNT_W:0]     trial;
  logic                           fits;

  // Shift in the next numerator bit and try to subtract the divisor.
  assign trial = {rem, quotient[anem_pkg::SPEED_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == anem_pkg::DIV_CNT_W'(anem_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Datapath: numerator and quotient share one shift register; the partial remainder has its own.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= numerator;
    end else if (busy) begin
      if (fits) begin
        rem <= anem_pkg::COUNT_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[anem_pkg::COUNT_W-1:0];
      end
      quotient <= {quotient[anem_pkg::SPEED_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/core/anem_limit_check.sv
// Limit comparison for temperature, pressure, humidity and wind speed,
// alarm latch next value and tone group priority. Depends on anem_pkg.
module anem_limit_check (
  input  anem_pkg::limits_t                  limits,
  input  logic signed [anem_pkg::TEMP_W-1:0] temperature,
  input  logic [anem_pkg::HUM_W-1:0]         humidity,
  input  logic [anem_pkg::PRES_W-1:0]        pressure,
  input  logic [anem_pkg::SPEED_W-1:0]       wind,
  input  logic                               latch,
  output anem_pkg::check_t                   result
);

  logic signed [11:0] t_ext, t_lim, t_lim_ext;
  logic [10:0] h_ext, h_lim, h_lim_ext;
  logic [14:0] p_ext, p_lim, p_lim_ext;
  logic [12:0] w_lim, w_lim_ext;
  logic t_hi, h_hi, p_hi, w_hi, all_lo;

  // Limits are in whole units; scale by ten as (x << 3) + (x << 1).
  assign t_lim_ext = 12'(signed'(limits.temperature));
  assign t_lim     = (t_lim_ext <<< 3) + (t_lim_ext <<< 1);
  assign h_lim_ext = 11'(limits.humidity);
  assign h_lim     = (h_lim_ext << 3) + (h_lim_ext << 1);
  assign p_lim_ext = 15'(limits.pressure);
  assign p_lim     = (p_lim_ext << 3) + (p_lim_ext << 1);
  assign w_lim_ext = 13'(limits.wind);
  assign w_lim     = (w_lim_ext << 3) + (w_lim_ext << 1);

  assign t_ext = 12'(temperature);
  assign h_ext = 11'(humidity);
  assign p_ext = 15'(pressure);

  // Above-limit flags and the all-below condition that releases the latch.
  assign t_hi   = t_ext > t_lim;
  assign h_hi   = h_ext > h_lim;
  assign p_hi   = p_ext > p_lim;
  assign w_hi   = wind > w_lim;
  assign all_lo = (t_ext < t_lim) && (h_ext < h_lim) && (p_ext < p_lim) && (wind < w_lim);

  // Latch update and tone priority: temperature, pressure, humidity, wind.
  always_comb begin
    if (!latch) begin
      result.latch_next = t_hi || h_hi || p_hi || w_hi;
    end else begin
      result.latch_next = !all_lo;
    end
    result.tone = anem_pkg::TONE_NONE;
    if (result.latch_next) begin
      if (t_hi) begin
        result.tone = anem_pkg::TONE_TEMPERATURE;
      end else if (p_hi) begin
        result.tone = anem_pkg::TONE_PRESSURE;
      end else if (h_hi) begin
        result.tone = anem_pkg::TONE_HUMIDITY;
      end else if (w_hi) begin
        result.tone = anem_pkg::TONE_WIND;
      end
    end
  end

endmodule

FILE: rtl/core/anemometer_speed_threshold_alarm.sv
// Top level of the anemometer speed and limit alarm block.
// Depends on anem_pkg, anem_divider and anem_limit_check.
//
// Usage:
//   One input beat per sensor tick on the s_axis channel carries the hall
//   level and the temperature, humidity and pressure samples. Each input
//   beat produces exactly one output beat on m_axis with the wind speed
//   in tenths of km/h, the alarm latch and the tone group.
//   Limits are written through the cfg channel (index 0 temperature,
//   1 humidity, 2 pressure, 3 wind); cfg_ready is always high and writes
//   are meant to happen only while the block is idle.
// Timing:
//   A falling hall edge with a nonzero period and no timeout runs the
//   restoring divider, one quotient bit per cycle, and the beat then
//   goes through the compare step to the output register. Any other beat
//   goes straight to the compare step. The next beat is taken only once
//   the last one has left the compare step: s_axis_tready is high only
//   while no beat is in progress.
// Reset:
//   rst (synchronous) restores the default limits, clears the period
//   counter, speed, timeout flag and alarm latch, and empties the output.
// Stalls:
//   A result waiting in the output register does not block a new input
//   beat; the next result waits in the compare step until m_axis_tready.
module anemometer_speed_threshold_alarm (
  input  logic                               clk,
  input  logic                               rst,
  // Input beat: hall_level[0], temperature_tenths[11:1], humidity_tenths[21:12],
  // pressure_tenths[35:22], zero pad [39:36]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [39:0]                        s_axis_tdata,
  // Output beat: wind_speed_tenths[12:0], alarm_active[13], tone_group[16:14],
  // zero pad [23:17]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [23:0]                        m_axis_tdata,
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [anem_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [anem_pkg::CFG_DATA_W-1:0]    cfg_data
);

  anem_pkg::state_t state, state_next;
  anem_pkg::limits_t limits;
  anem_pkg::check_t  check;

  logic                               prev_hall;
  logic [anem_pkg::COUNT_W-1:0]       period_count;
  logic                               timed_out;
  logic [anem_pkg::SPEED_W-1:0]       wind_speed;
  logic                               alarm_latch;

  logic signed [anem_pkg::TEMP_W-1:0] temperature;
  logic [anem_pkg::HUM_W-1:0]         humidity;
  logic [anem_pkg::PRES_W-1:0]        pressure;

  logic                               in_hall;
  logic                               in_accept;
  logic                               rise, fall;
  logic                               div_start, div_busy, div_done;
  logic [anem_pkg::SPEED_W-1:0]       div_quotient;
  logic                               out_load;

  logic [anem_pkg::SPEED_W-1:0]       out_speed;
  logic                               out_alarm;
  anem_pkg::tone_t                    out_tone;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == anem_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_hall       = s_axis_tdata[0];
  assign rise          = !prev_hall && in_hall;
  assign fall          = prev_hall && !in_hall;
  assign div_start     = in_accept && fall && !timed_out && (period_count != '0);
  assign out_load      = (state == anem_pkg::ST_CMP) && (!m_axis_tvalid || m_axis_tready);

  assign m_axis_tdata  = {7'd0, out_tone, out_alarm, out_speed};

  // Limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.temperature <= anem_pkg::TEMP_LIM_RESET;
      limits.humidity    <= anem_pkg::HUM_LIM_RESET;
      limits.pressure    <= anem_pkg::PRES_LIM_RESET;
      limits.wind        <= anem_pkg::WIND_LIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        anem_pkg::CFG_TEMPERATURE: limits.temperature <= cfg_data[anem_pkg::TEMP_LIM_W-1:0];
        anem_pkg::CFG_HUMIDITY:    limits.humidity    <= cfg_data[anem_pkg::HUM_LIM_W-1:0];
        anem_pkg::CFG_PRESSURE:    limits.pressure    <= cfg_data[anem_pkg::PRES_LIM_W-1:0];
        anem_pkg::CFG_WIND:        limits.wind        <= cfg_data[anem_pkg::WIND_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= anem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: divide only when a falling edge needs a fresh speed.
  always_comb begin
    state_next = state;
    unique case (state)
      anem_pkg::ST_IDLE: begin
        if (div_start) begin
          state_next = anem_pkg::ST_DIV;
        end else if (in_accept) begin
          state_next = anem_pkg::ST_CMP;
        end
      end
      anem_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = anem_pkg::ST_CMP;
        end
      end
      anem_pkg::ST_CMP: begin
        if (out_load) begin
          state_next = anem_pkg::ST_IDLE;
        end
      end
      default: state_next = anem_pkg::ST_IDLE;
    endcase
  end

  // Hall edge handling, period counter and timeout.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_hall    <= 1'b0;
      period_count <= '0;
      timed_out    <= 1'b0;
      wind_speed   <= '0;
    end else if (in_accept) begin
      prev_hall <= in_hall;
      if (rise) begin
        period_count <= '0;
        timed_out    <= 1'b0;
      end else begin
        if (fall) begin
          if (!timed_out && (period_count == '0)) begin
            wind_speed <= anem_pkg::SPEED_NUMERATOR;
          end
        end else if (period_count > anem_pkg::TIMEOUT_TICKS) begin
          wind_speed <= '0;
          timed_out  <= 1'b1;
        end
        if (period_count != anem_pkg::COUNT_MAX) begin
          period_count <= period_count + 1'b1;
        end
      end
    end else if (div_done) begin
      wind_speed <= div_quotient;
    end
  end

  // Sample capture for the compare step.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      temperature <= s_axis_tdata[11:1];
      humidity    <= s_axis_tdata[21:12];
      pressure    <= s_axis_tdata[35:22];
    end
  end

  // Alarm latch and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_latch   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        alarm_latch   <= check.latch_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speed <= wind_speed;
      out_alarm <= check.latch_next;
      out_tone  <= check.tone;
    end
  end

  anem_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (anem_pkg::SPEED_NUMERATOR),
    .divisor   (period_count),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quotient)
  );

  anem_limit_check u_check (
    .limits      (limits),
    .temperature (temperature),
    .humidity    (humidity),
    .pressure    (pressure),
    .wind        (wind_speed),
    .latch       (alarm_latch),
    .result      (check)
  );

  // While the sequencer waits for the divider, the divider is running.
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    (state == anem_pkg::ST_DIV) |-> (div_busy || div_done))
    else $error("sequencer waits for a divider that is not running");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == anem_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

  // A timeout can only stand while the period counter is past the limit.
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    timed_out |-> (period_count > anem_pkg::TIMEOUT_TICKS))
    else $error("timeout flag set with a short period count");

  // A new result appears only out of the compare step.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == anem_pkg::ST_CMP))
    else $error("output beat raised outside the compare step");

endmodule

FILE: bench/anemometer_speed_threshold_alarm_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for anemometer_speed_threshold_alarm: streams sensor ticks,
// predicts wind speed, alarm latch and tone group per tick and scores every beat.
// Depends on anem_pkg and the anemometer_speed_threshold_alarm RTL.

module anemometer_speed_threshold_alarm_tb;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASE_TICKS  = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  // One expected output beat.
  typedef struct {
    logic [anem_pkg::SPEED_W-1:0] speed;
    logic                         alarm;
    anem_pkg::tone_t              tone;
  } reading_t;

  // Scoreboard: tracks the station state per accepted tick and holds the
  // readings still owed by the block.
  class alarm_scoreboard;
    logic signed [anem_pkg::TEMP_LIM_W-1:0] temp_lim;
    logic [anem_pkg::HUM_LIM_W-1:0]         hum_lim;
    logic [anem_pkg::PRES_LIM_W-1:0]        pres_lim;
    logic [anem_pkg::WIND_LIM_W-1:0]        wind_lim;
    bit                                     prev_hall;
    logic [anem_pkg::COUNT_W-1:0]           period;
    bit                                     timed_out;
    logic [anem_pkg::SPEED_W-1:0]           speed;
    bit                                     latch;
    reading_t                               expected_readings[$];
    int mismatches, checked, speed_updates, timeouts, alarm_sets;
    int tone_hits[5];

    function new();
      temp_lim  = anem_pkg::TEMP_LIM_RESET;
      hum_lim   = anem_pkg::HUM_LIM_RESET;
      pres_lim  = anem_pkg::PRES_LIM_RESET;
      wind_lim  = anem_pkg::WIND_LIM_RESET;
      prev_hall = 0;
      period    = '0;
      timed_out = 0;
      speed     = '0;
      latch     = 0;
      foreach (tone_hits[i]) tone_hits[i] = 0;
    endfunction

    function void set_limit(logic [anem_pkg::CFG_INDEX_W-1:0] index,
                            logic [anem_pkg::CFG_DATA_W-1:0] value);
      case (index)
        anem_pkg::CFG_TEMPERATURE: temp_lim = value[anem_pkg::TEMP_LIM_W-1:0];
        anem_pkg::CFG_HUMIDITY:    hum_lim  = value[anem_pkg::HUM_LIM_W-1:0];
        anem_pkg::CFG_PRESSURE:    pres_lim = value[anem_pkg::PRES_LIM_W-1:0];
        anem_pkg::CFG_WIND:        wind_lim = value[anem_pkg::WIND_LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the station by one accepted tick and queue the reading it owes.
    function void note_tick(logic [39:0] beat);
      logic                               hall;
      logic signed [anem_pkg::TEMP_W-1:0] t;
      logic [anem_pkg::HUM_W-1:0]         h;
      logic [anem_pkg::PRES_W-1:0]        p;
      int tl, hl, pl, wl, ti, hi, pi, wi;
      bit t_hi, h_hi, p_hi, w_hi, all_lo;
      reading_t r;
      hall = beat[0];
      t    = beat[11:1];
      h    = beat[21:12];
      p    = beat[35:22];

      // Hall edge handling and period counting.
      if (!prev_hall && hall) begin
        period    = '0;
        timed_out = 0;
      end else begin
        if (prev_hall && !hall) begin
          if (!timed_out) begin
            speed = (period == 0) ? anem_pkg::SPEED_NUMERATOR :
                    anem_pkg::SPEED_NUMERATOR / anem_pkg::SPEED_W'(period);
            speed_updates++;
          end
        end else if (period > anem_pkg::TIMEOUT_TICKS) begin
          if (!timed_out) timeouts++;
          speed     = '0;
          timed_out = 1;
        end
        if (period < anem_pkg::COUNT_MAX) period++;
      end
      prev_hall = hall;

      // Limit comparison in tenths.
      tl = int'(temp_lim) * 10;
      hl = int'(hum_lim) * 10;
      pl = int'(pres_lim) * 10;
      wl = int'(wind_lim) * 10;
      ti = int'(t);
      hi = int'(h);
      pi = int'(p);
      wi = int'(speed);
      t_hi   = ti > tl;
      h_hi   = hi > hl;
      p_hi   = pi > pl;
      w_hi   = wi > wl;
      all_lo = (ti < tl) && (hi < hl) && (pi < pl) && (wi < wl);

      // Alarm latch with hysteresis: set on any above, clear on all below.
      if (!latch) begin
        if (t_hi || h_hi || p_hi || w_hi) begin
          latch = 1;
          alarm_sets++;
        end
      end else if (all_lo) begin
        latch = 0;
      end

      r.speed = speed;
      r.alarm = latch;
      r.tone  = anem_pkg::TONE_NONE;
      if (latch) begin
        if (t_hi)      r.tone = anem_pkg::TONE_TEMPERATURE;
        else if (p_hi) r.tone = anem_pkg::TONE_PRESSURE;
        else if (h_hi) r.tone = anem_pkg::TONE_HUMIDITY;
        else if (w_hi) r.tone = anem_pkg::TONE_WIND;
      end
      expected_readings.push_back(r);
    endfunction

    // Compare one output beat with the oldest owed reading.
    function void check_reading(logic [23:0] data);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $error("output beat with nothing expected, tdata %h", data);
        mismatches++;
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      tone_hits[int'(want.tone)]++;
      if (data[12:0] !== want.speed) begin
        $error("wind_speed_tenths mismatch: expected %0d, actual %0d", want.speed, data[12:0]);
        mismatches++;
      end
      if (data[13] !== want.alarm) begin
        $error("alarm_active mismatch: expected %0d, actual %0d", want.alarm, data[13]);
        mismatches++;
      end
      if (data[16:14] !== want.tone) begin
        $error("tone_group mismatch: expected %0d, actual %0d", want.tone, data[16:14]);
        mismatches++;
      end
      if (data[23:17] !== 7'd0) begin
        $error("tdata pad mismatch: expected 0, actual %0d", data[23:17]);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk           = 1'b0;
  logic                             rst           = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [39:0]                      s_axis_tdata  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [23:0]                      m_axis_tdata;
  logic                             cfg_valid     = 1'b0;
  logic                             cfg_ready;
  logic [anem_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [anem_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

  alarm_scoreboard sb;
  int burst_left      = 0;
  int ticks_sent      = 0;
  int limit_settings  = 1;
  int cycle_count;
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  int rx_mode         = 0;
  int rx_mode_left    = 0;
  int unsigned rx_phase = 0;
  bit rx_next;

  anemometer_speed_threshold_alarm dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Output side: score accepted beats, then choose the next ready level.
  // Stall style is redrawn at random when its run ends; a requested hold keeps
  // ready low for a long stretch so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_reading(m_axis_tdata);
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(32, 256);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        0:       rx_next = 1'b1;
        1:       rx_next = $urandom_range(0, 1);
        2:       rx_next = ($urandom_range(0, 3) == 0);
        default: rx_next = (rx_phase % 5) < 2;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rx_next = 1'b0;
      end else if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        rx_next   = 1'b0;
      end
      m_axis_tready <= rx_next;
    end
  end

  // Run limit.
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clk);
    $display("Timed out after %0d cycles with %0d readings outstanding",
             cycle_count, sb.expected_readings.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [39:0] pack_beat(bit hall, int t, int h, int p);
    return {4'b0000, 14'(p), 10'(h), 11'(t), hall};
  endfunction

  // Sample style: 0 below the nonzero limits, 1 close to the limits, 2 any bits.
  function automatic int pick_sample_mode();
    int r;
    r = $urandom_range(0, 99);
    return (r < 45) ? 0 : (r < 75) ? 1 : 2;
  endfunction

  function automatic logic [39:0] weather_beat(bit hall, int mode);
    int tl, hl, pl, t, h, p;
    tl = int'(sb.temp_lim) * 10;
    hl = int'(sb.hum_lim) * 10;
    pl = int'(sb.pres_lim) * 10;
    case (mode)
      0: begin
        t = tl - int'($urandom_range(1, 300));
        h = (hl == 0) ? 0 : hl - int'($urandom_range(1, (hl < 200) ? hl : 200));
        p = pl - int'($urandom_range(1, 2000));
      end
      1: begin
        t = tl + int'($urandom_range(0, 4)) - 2;
        h = hl + int'($urandom_range(0, 4)) - 2;
        p = pl + int'($urandom_range(0, 4)) - 2;
      end
      default: begin
        t = $urandom;
        h = $urandom;
        p = $urandom;
      end
    endcase
    return pack_beat(hall, t, h, p);
  endfunction

  // Offer one tick; bursts of random length are separated by random gaps.
  task automatic send_beat(input logic [39:0] beat);
    int gap, r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      r   = $urandom_range(0, 99);
      gap = (r < 30) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(5, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(beat);
    ticks_sent++;
  endtask

  task automatic send_fields(bit hall, int t, int h, int p);
    send_beat(pack_beat(hall, t, h, p));
  endtask

  task automatic write_reg(logic [anem_pkg::CFG_INDEX_W-1:0] index,
                           logic [anem_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(index, value);
  endtask

  // Drain the block, then load a new set of limits.
  task automatic set_limits(int t, int h, int p, int w);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    write_reg(anem_pkg::CFG_TEMPERATURE, {3'b000, 8'(t)});
    write_reg(anem_pkg::CFG_HUMIDITY, anem_pkg::CFG_DATA_W'(h));
    write_reg(anem_pkg::CFG_PRESSURE, anem_pkg::CFG_DATA_W'(p));
    write_reg(anem_pkg::CFG_WIND, anem_pkg::CFG_DATA_W'(w));
    cfg_valid <= 1'b0;
    limit_settings++;
  endtask

  // Mostly whole rotor periods (rise, high run, fall, low run) with random
  // samples; the rest is random hall noise that breaks the pattern.
  task automatic run_weather(int n);
    int sent, r, high_ticks, low_ticks;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 6)) begin
          send_beat(weather_beat($urandom_range(0, 1), pick_sample_mode()));
          sent++;
        end
      end else begin
        r = $urandom_range(0, 99);
        high_ticks = (r < 30) ? $urandom_range(0, 15) :
                     (r < 85) ? $urandom_range(16, 150) : $urandom_range(151, 400);
        low_ticks  = $urandom_range(0, 40);
        send_beat(weather_beat(1, pick_sample_mode()));
        repeat (high_ticks) send_beat(weather_beat(1, pick_sample_mode()));
        send_beat(weather_beat(0, pick_sample_mode()));
        repeat (low_ticks) send_beat(weather_beat(0, pick_sample_mode()));
        sent += high_ticks + low_ticks + 2;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at the reset limits (400, 800, 10500, 100 in tenths).
    send_fields(0, 0, 0, 0);
    send_fields(1, -1024, 0, 0);
    // Fall right after the rise: zero period saturates to the full numerator.
    send_fields(0, 0, 0, 0);
    send_fields(1, 0, 0, 0);
    send_fields(1, 0, 0, 0);
    send_fields(0, 0, 0, 0);
    // Tone priority, with out-of-range field extremes.
    send_fields(0, 1023, 1023, 16383);
    send_fields(0, 400, 1023, 16383);
    send_fields(0, 400, 1023, 10500);
    send_fields(0, 400, 800, 10500);
    // Long high stretch just past the timeout, which forces speed to zero.
    // Temperature sits on its limit, so once speed is zero the latch holds with no tone.
    send_fields(1, 400, 0, 0);
    repeat (2010) send_fields(1, 400, 0, 0);
    // Fall after timeout keeps the zeroed speed.
    send_fields(0, 400, 0, 0);
    send_fields(0, 0, 0, 0);
    send_fields(0, 400, 800, 10500);
    send_fields(0, 401, 800, 10500);

    // Random weather at the reset limits, with one long output hold.
    holds_requested <= holds_requested + 1;
    run_weather(PHASE_TICKS);
    set_limits(-40, 0, 300, 0);
    run_weather(PHASE_TICKS);
    set_limits(85, 100, 1100, 50);
    run_weather(PHASE_TICKS);
    repeat (3) begin
      set_limits(int'($urandom_range(0, 125)) - 40, $urandom_range(0, 100),
                 $urandom_range(300, 1100), $urandom_range(0, 50));
      run_weather(PHASE_TICKS);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks over %0d limit settings: %0d speed updates,",
             ticks_sent, limit_settings, sb.speed_updates);
    $display("%0d timeouts, %0d alarm sets; tone groups (none/temp/pres/hum/wind): %0d %0d %0d %0d %0d",
             sb.timeouts, sb.alarm_sets, sb.tone_hits[0], sb.tone_hits[1],
             sb.tone_hits[2], sb.tone_hits[3], sb.tone_hits[4]);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/anem_pkg.sv
rtl/core/anem_divider.sv
rtl/core/anem_limit_check.sv
rtl/core/anemometer_speed_threshold_alarm.sv
bench/anemometer_speed_threshold_alarm_tb.sv
